FILE: rtl/core/sahc_pkg.sv
package sahc_pkg;

  localparam int SET_INDEX_BITS = 4;
  localparam int NUM_WAYS       = 4;
  localparam int NUM_SETS       = 1 << SET_INDEX_BITS;
  localparam int WAY_W          = $clog2(NUM_WAYS);
  localparam int OWNER_SHIFT    = 6;
  localparam logic [63:0] HASH_MULT = 64'h61C8864680B583EB;

  typedef enum logic [1:0] {
    CMD_LOOKUP   = 2'd0,
    CMD_INSERT   = 2'd1,
    CMD_READ_CNT = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_MISS     = 3'd0,
    ST_HIT      = 3'd1,
    ST_STALE    = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_DUP      = 3'd4,
    ST_STORED   = 3'd5,
    ST_CNT_READ = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    SEL_HIT   = 3'd0,
    SEL_MISS  = 3'd1,
    SEL_STALE = 3'd2,
    SEL_FILL  = 3'd3,
    SEL_EVICT = 3'd4
  } cnt_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_READ,
    S_EXEC
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MUL_LL,
    MUL_HL,
    MUL_LH
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef struct packed {
    logic [63:0] owner;
    logic [63:0] page;
    logic [63:0] handle;
  } way_t;

  typedef way_t [NUM_WAYS-1:0] row_t;

  typedef struct packed {
    logic     req_load;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     rd_en;
    logic     exec;
  } dp_cmd_t;

endpackage

FILE: rtl/core/set_assoc_handle_cache_core.sv
// Set-associative handle cache: 16 sets of 4 ways keyed by (owner, page),
// round-robin replacement, five readable wrapping counters. One request is
// in flight at a time; after acceptance it takes three partial products on a
// shared 32x32 multiplier, summed into the set hash, one registered read of
// the set's row, and a compare of the ways with write back. The controller
// then returns to idle, ready for input, so no request is accepted before
// the previous one has finished. A new request is taken while the previous
// result waits.
module set_assoc_handle_cache_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] owner_key_i,
  input  logic [63:0] page_key_i,
  input  logic [63:0] handle_in_i,
  input  logic [63:0] handle_owner_i,
  input  logic [2:0]  counter_select_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] value_out_o,
  output logic        evicted_o
);
  import sahc_pkg::*;

  dp_cmd_t dp_cmd;

  sahc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd)
  );

  sahc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_cmd_i        (cmd_i),
    .owner_key_i      (owner_key_i),
    .page_key_i       (page_key_i),
    .handle_in_i      (handle_in_i),
    .handle_owner_i   (handle_owner_i),
    .counter_select_i (counter_select_i),
    .status_o         (status_o),
    .value_out_o      (value_out_o),
    .evicted_o        (evicted_o)
  );

endmodule

FILE: rtl/core/sahc_ctrl.sv
module sahc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sahc_pkg::dp_cmd_t cmd_o
);
  import sahc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '{req_load: 1'b0, mul_sel: MUL_LL, acc_op: ACC_HOLD,
                    rd_en: 1'b0, exec: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd_o.mul_sel = MUL_LL;
        state_d       = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_sel = MUL_HL;
        cmd_o.acc_op  = ACC_LOAD;
        state_d       = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_sel = MUL_LH;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = S_SUM;
      end
      S_SUM: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = S_READ;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/sahc_datapath.sv
module sahc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sahc_pkg::dp_cmd_t cmd_i,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic [1:0]        req_cmd_i,
  input  logic [63:0]       owner_key_i,
  input  logic [63:0]       page_key_i,
  input  logic [63:0]       handle_in_i,
  input  logic [63:0]       handle_owner_i,
  input  logic [2:0]        counter_select_i,
  output logic [2:0]        status_o,
  output logic [63:0]       value_out_o,
  output logic              evicted_o
);
  import sahc_pkg::*;

  // request registers
  cmd_e        cmd_q;
  cnt_sel_e    sel_q;
  logic [63:0] owner_q, page_q, handle_q, howner_q;

  // hash
  logic [63:0] key;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_q;
  logic [63:0] acc_q;
  logic [SET_INDEX_BITS-1:0] rd_set;

  // storage
  row_t                      mem_q [NUM_SETS];
  logic [NUM_SETS-1:0]       set_valid_q;
  logic [WAY_W-1:0]          victim_q [NUM_SETS];
  row_t                      rd_row_q;
  logic                      rd_valid_q;
  logic [SET_INDEX_BITS-1:0] set_q;

  logic        enable_q;
  logic [63:0] hit_cnt_q, miss_cnt_q, stale_cnt_q, fill_cnt_q, evict_cnt_q;

  status_e     status_q, status_d;
  logic [63:0] value_q, value_d;
  logic        evicted_q, evicted_d;

  // execute stage
  row_t               row, new_row;
  logic               hit_found, empty_found;
  logic [WAY_W-1:0]   hit_way, empty_way, pick, victim, victim_next;
  logic [63:0]        hit_handle, old_handle;
  logic               ins_ok, dup;
  logic               do_write, adv_victim;
  logic               inc_hit, inc_miss, inc_stale, inc_fill, inc_evict;

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      cmd_q    <= cmd_e'(req_cmd_i);
      sel_q    <= cnt_sel_e'(counter_select_i);
      owner_q  <= owner_key_i;
      page_q   <= page_key_i;
      handle_q <= handle_in_i;
      howner_q <= handle_owner_i;
    end
  end

  assign key = (owner_q >> OWNER_SHIFT) ^ page_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_LL: begin
        mul_a = key[31:0];
        mul_b = HASH_MULT[31:0];
      end
      MUL_HL: begin
        mul_a = key[63:32];
        mul_b = HASH_MULT[31:0];
      end
      MUL_LH: begin
        mul_a = key[31:0];
        mul_b = HASH_MULT[63:32];
      end
      default: begin
        mul_a = key[31:0];
        mul_b = HASH_MULT[31:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
    case (cmd_i.acc_op)
      ACC_LOAD: acc_q <= prod_q;
      ACC_ADD:  acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
      default:  acc_q <= acc_q;
    endcase
  end

  assign rd_set = acc_q[63 -: SET_INDEX_BITS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_row_q <= mem_q[rd_set];
      set_q    <= rd_set;
    end
    if (do_write) begin
      mem_q[set_q] <= new_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      enable_q    <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      stale_cnt_q <= '0;
      fill_cnt_q  <= '0;
      evict_cnt_q <= '0;
      for (int s = 0; s < NUM_SETS; s++) begin
        victim_q[s] <= '0;
      end
    end else begin
      if (cfg_we_i) enable_q <= cfg_wdata_i;
      if (cmd_i.rd_en) rd_valid_q <= set_valid_q[rd_set];
      if (do_write) set_valid_q[set_q] <= 1'b1;
      if (adv_victim) victim_q[set_q] <= victim_next;
      if (inc_hit)   hit_cnt_q   <= hit_cnt_q + 64'd1;
      if (inc_miss)  miss_cnt_q  <= miss_cnt_q + 64'd1;
      if (inc_stale) stale_cnt_q <= stale_cnt_q + 64'd1;
      if (inc_fill)  fill_cnt_q  <= fill_cnt_q + 64'd1;
      if (inc_evict) evict_cnt_q <= evict_cnt_q + 64'd1;
    end
  end

  always_comb begin
    row         = rd_valid_q ? rd_row_q : '0;
    hit_found   = 1'b0;
    empty_found = 1'b0;
    hit_way     = '0;
    empty_way   = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row[w].owner == owner_q && row[w].page == page_q) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(w);
      end
      if (row[w].handle == 64'd0) begin
        empty_found = 1'b1;
        empty_way   = WAY_W'(w);
      end
    end
    hit_handle  = row[hit_way].handle;
    victim      = victim_q[set_q];
    victim_next = (victim == WAY_W'(NUM_WAYS - 1)) ? '0 : victim + WAY_W'(1);
    pick        = hit_found ? hit_way : (empty_found ? empty_way : victim);
    old_handle  = row[pick].handle;
    ins_ok      = enable_q && (howner_q == owner_q) && (handle_q != 64'd0);
    dup         = hit_found && (hit_handle == handle_q);
    new_row     = row;
    new_row[pick] = '{owner: owner_q, page: page_q, handle: handle_q};

    status_d   = ST_MISS;
    value_d    = 64'd0;
    evicted_d  = 1'b0;
    do_write   = 1'b0;
    adv_victim = 1'b0;
    inc_hit    = 1'b0;
    inc_miss   = 1'b0;
    inc_stale  = 1'b0;
    inc_fill   = 1'b0;
    inc_evict  = 1'b0;

    case (cmd_q)
      CMD_LOOKUP: begin
        if (enable_q) begin
          if (hit_found) begin
            if (hit_handle == 64'd0) begin
              status_d  = ST_STALE;
              inc_stale = cmd_i.exec;
            end else begin
              status_d = ST_HIT;
              value_d  = hit_handle;
              inc_hit  = cmd_i.exec;
            end
          end else begin
            inc_miss = cmd_i.exec;
          end
        end
      end
      CMD_INSERT: begin
        if (!ins_ok) begin
          status_d = ST_IGNORED;
        end else if (dup) begin
          status_d = ST_DUP;
        end else begin
          status_d   = ST_STORED;
          value_d    = old_handle;
          evicted_d  = (old_handle != 64'd0);
          do_write   = cmd_i.exec;
          adv_victim = cmd_i.exec && !hit_found && !empty_found;
          inc_fill   = cmd_i.exec;
          inc_evict  = cmd_i.exec && (old_handle != 64'd0);
        end
      end
      CMD_READ_CNT: begin
        status_d = ST_CNT_READ;
        case (sel_q)
          SEL_HIT:   value_d = hit_cnt_q;
          SEL_MISS:  value_d = miss_cnt_q;
          SEL_STALE: value_d = stale_cnt_q;
          SEL_FILL:  value_d = fill_cnt_q;
          SEL_EVICT: value_d = evict_cnt_q;
          default:   value_d = 64'd0;
        endcase
      end
      default: begin
        status_d = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q  <= status_d;
      value_q   <= value_d;
      evicted_q <= evicted_d;
    end
  end

  assign status_o    = status_q;
  assign value_out_o = value_q;
  assign evicted_o   = evicted_q;

endmodule
